// File: rtl/core/fpb_pkg.sv
// Shared constants and types for the point transform / bounding box block.
// No dependencies; imported by the front, back, top level and checker.
`default_nettype none
package fpb_pkg;

  // configuration port geometry
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int SLOT_W     = 16;   // one coefficient slot in a column register

  // column register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_COL = 2'd0,
    REG_Y_COL = 2'd1,
    REG_Z_COL = 2'd2,
    REG_W_COL = 2'd3
  } cfg_reg_t;

  // back-end sequencer states
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_MUL    = 7'b0000010,
    ST_ACC    = 7'b0000100,
    ST_DSETUP = 7'b0001000,
    ST_DIV    = 7'b0010000,
    ST_DDONE  = 7'b0100000,
    ST_UPDATE = 7'b1000000
  } back_state_t;

endpackage
`default_nettype wire

// File: rtl/core/transform_points_bounding_box.sv
// Top level: point transform with bounding box; front queue plus back end.
// Depends on fpb_pkg, fpb_front, fpb_back.
//
//   channel   dir  tdata (low bit up)                       side band
//   s_*       in   point_x, point_y, point_z                tlast = last_point
//   m_*       out  min_x, min_y, min_z, max_x, max_y, max_z tuser = divide_fault
//   cfg_*     in   cfg_index selects x/y/z/w column         write only
//
// In the back end a point passes through the shared multiplier (16 multiply/accumulate
// steps, each a multiply state then an accumulate state) and then, when w is nonzero,
// the one-bit-per-cycle divider, run once per axis; a zero w skips the divider.
// The two-entry queue takes new points while the back end is busy.
// rst is synchronous; it restores the identity matrix and empties the batch.
// A last point waits in the back end while the box register is still held.
`default_nettype none
module transform_points_bounding_box
  import fpb_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_WIDTH  = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [((3*COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // point_x, point_y,
                                                                   // point_z, zero pad
  input  wire logic                    s_tlast,
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic [((6*COORD_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,  // min_x..z, max_x..z,
                                                              // zero pad
  output logic                         m_tuser,   // divide_fault
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int OUT_W = ((6*COORD_WIDTH + 7) / 8) * 8;

  logic                      q_valid;
  logic                      q_ready;
  logic [3*COORD_WIDTH:0]    q_entry;
  logic [6*COORD_WIDTH-1:0]  box;

  fpb_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_point  (s_tdata[3*COORD_WIDTH-1:0]),
    .s_tlast  (s_tlast),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_entry  (q_entry)
  );

  fpb_back #(.COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_entry   (q_entry),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_box     (box),
    .m_fault   (m_tuser)
  );

  assign m_tdata = OUT_W'(box);

endmodule
`default_nettype wire

// File: rtl/core/fpb_front.sv
// Input side: takes point transfers and queues them (two entries) for the back end.
// Depends on fpb_pkg.
`default_nettype none
module fpb_front
  import fpb_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [3*COORD_WIDTH-1:0]   s_point,
  input  wire logic                       s_tlast,
  output logic                            q_valid,
  input  wire logic                       q_ready,
  output logic [3*COORD_WIDTH:0]          q_entry    // {last, z, y, x}
);

  localparam int EW = 3*COORD_WIDTH + 1;

  logic [EW-1:0] slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  logic          pop;

  assign s_tready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_entry  = slots[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= {s_tlast, s_point};
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/fpb_back.sv
// Back end: shared multiply-accumulate for the 4x4 transform, bit-serial divider,
// running min/max and the output register. Depends on fpb_pkg.
`default_nettype none
module fpb_back
  import fpb_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_WIDTH  = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                       q_valid,
  output logic                            q_ready,
  input  wire logic [3*COORD_WIDTH:0]     q_entry,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [6*COORD_WIDTH-1:0]        m_box,
  output logic                            m_fault
);

  localparam int CW   = COORD_WIDTH;
  localparam int KW   = COEF_WIDTH;
  localparam int CF   = CW / 2;
  localparam int PW   = CW + KW;
  localparam int TS   = (PW > 61) ? (PW - 61) : 0;
  localparam int TW   = PW - TS;
  localparam int SW   = TW + 2;
  localparam int QW   = SW + CF;
  localparam int CNTW = $clog2(QW + 1);

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] ONE  = CW'(1) << CF;

  back_state_t            state;
  logic [CFG_DATA_W-1:0]  col_reg [4];
  logic signed [CW-1:0]   pt [3];
  logic                   last;
  logic [1:0]             col;
  logic [1:0]             slot;
  logic signed [PW-1:0]   prod;
  logic signed [SW-1:0]   acc;
  logic signed [SW-1:0]   num [4];
  logic [1:0]             axis;
  logic [QW-1:0]          dvd;
  logic [QW-1:0]          quo;
  logic [SW:0]            rem;
  logic [SW-1:0]          den_mag;
  logic                   neg;
  logic [CNTW-1:0]        cnt;
  logic signed [CW-1:0]   t [3];
  logic signed [CW-1:0]   low [3];
  logic signed [CW-1:0]   high [3];
  logic signed [CW-1:0]   nlow [3];
  logic signed [CW-1:0]   nhigh [3];
  logic                   have_point;
  logic                   fault_seen;

  // datapath helpers
  logic signed [CW-1:0]   mul_a;
  logic signed [KW-1:0]   mul_b;
  logic [CFG_DATA_W-1:0]  cur_col;
  logic signed [PW-1:0]   term_full;
  logic signed [SW-1:0]   term;
  logic signed [SW-1:0]   acc_sum;
  logic signed [SW-1:0]   n_sel;
  logic signed [SW-1:0]   d_sel;
  logic [SW:0]            rem_sh;
  logic                   rem_ge;
  logic                   q_ovf;
  logic signed [CW-1:0]   q_val;
  logic                   out_free;
  logic                   emit;

  assign cur_col   = col_reg[col];
  assign mul_b     = cur_col[{slot, 4'b0000} +: KW];
  assign term_full = prod >>> TS;
  assign term      = SW'(signed'(term_full[TW-1:0]));
  assign acc_sum   = acc + term;
  assign n_sel     = num[axis];
  assign d_sel     = num[REG_W_COL];
  assign rem_sh    = {rem[SW-1:0], dvd[QW-1]};
  assign rem_ge    = (rem_sh >= {1'b0, den_mag});
  assign q_ovf     = |quo[QW-1:CW-1];
  assign q_val     = q_ovf ? (neg ? CMIN : CMAX)
                           : (neg ? -signed'(quo[CW-1:0]) : signed'(quo[CW-1:0]));
  assign out_free  = !last || !m_tvalid || m_tready;
  assign emit      = (state == ST_UPDATE) && out_free && last;
  assign q_ready   = (state == ST_IDLE);

  // multiplier operand: coordinate or the constant 1.0
  always_comb begin
    case (slot)
      2'd0:    mul_a = pt[0];
      2'd1:    mul_a = pt[1];
      2'd2:    mul_a = pt[2];
      default: mul_a = ONE;
    endcase
  end

  // bounds after this point
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nlow[i]  = (!have_point || t[i] < low[i])  ? t[i] : low[i];
      nhigh[i] = (!have_point || t[i] > high[i]) ? t[i] : high[i];
    end
  end

  // column registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        col_reg[i] <= CFG_DATA_W'(1) << (KW - 4 + SLOT_W*i);
      end
    end else if (cfg_we) begin
      col_reg[cfg_index] <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      have_point <= 1'b0;
      fault_seen <= 1'b0;
      m_tvalid   <= 1'b0;
      col        <= 2'd0;
      slot       <= 2'd0;
      axis       <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        low[i]  <= '0;
        high[i] <= '0;
      end
    end else begin
      if (m_tready && !emit) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            pt[0] <= q_entry[CW-1:0];
            pt[1] <= q_entry[2*CW-1:CW];
            pt[2] <= q_entry[3*CW-1:2*CW];
            last  <= q_entry[3*CW];
            col   <= 2'd0;
            slot  <= 2'd0;
            acc   <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= mul_a * mul_b;
          state <= ST_ACC;
        end
        ST_ACC: begin
          if (slot == 2'd3) begin
            num[col] <= acc_sum;
            acc      <= '0;
            slot     <= 2'd0;
            if (col == 2'd3) begin
              axis  <= 2'd0;
              state <= ST_DSETUP;
            end else begin
              col   <= col + 2'd1;
              state <= ST_MUL;
            end
          end else begin
            acc   <= acc_sum;
            slot  <= slot + 2'd1;
            state <= ST_MUL;
          end
        end
        ST_DSETUP: begin
          if (d_sel == '0) begin
            // zero divisor: saturate by numerator sign
            if (n_sel[SW-1])      t[axis] <= CMIN;
            else if (n_sel != '0) t[axis] <= CMAX;
            else                  t[axis] <= '0;
            fault_seen <= 1'b1;
            if (axis == 2'd2) state <= ST_UPDATE;
            else              axis  <= axis + 2'd1;
          end else begin
            neg     <= n_sel[SW-1] ^ d_sel[SW-1];
            dvd     <= {(n_sel[SW-1] ? SW'(-n_sel) : SW'(n_sel)), {CF{1'b0}}};
            den_mag <= d_sel[SW-1] ? SW'(-d_sel) : SW'(d_sel);
            rem     <= '0;
            quo     <= '0;
            cnt     <= CNTW'(QW);
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          dvd <= dvd << 1;
          rem <= rem_ge ? (rem_sh - {1'b0, den_mag}) : rem_sh;
          quo <= {quo[QW-2:0], rem_ge};
          cnt <= cnt - CNTW'(1);
          if (cnt == CNTW'(1)) state <= ST_DDONE;
        end
        ST_DDONE: begin
          t[axis] <= q_val;
          if (axis == 2'd2) begin
            state <= ST_UPDATE;
          end else begin
            axis  <= axis + 2'd1;
            state <= ST_DSETUP;
          end
        end
        ST_UPDATE: begin
          if (out_free) begin
            if (last) begin
              for (int i = 0; i < 3; i++) begin
                m_box[i*CW +: CW]     <= nlow[i];
                m_box[(3+i)*CW +: CW] <= nhigh[i];
                low[i]  <= '0;
                high[i] <= '0;
              end
              m_fault    <= fault_seen;
              m_tvalid   <= 1'b1;
              have_point <= 1'b0;
              fault_seen <= 1'b0;
            end else begin
              for (int i = 0; i < 3; i++) begin
                low[i]  <= nlow[i];
                high[i] <= nhigh[i];
              end
              have_point <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/fpb_checker.sv
// Port-level checks for transform_points_bounding_box, attached by bind.
// Imports fpb_pkg but uses nothing from it; port widths come from COORD_WIDTH.
`default_nettype none
module fpb_checker
  import fpb_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    m_tvalid,
  input wire logic                    m_tready,
  input wire logic [6*COORD_WIDTH-1:0] m_box,
  input wire logic                    m_tuser
);

  localparam int CW = COORD_WIDTH;

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // a stalled box transfer holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_box) && $stable(m_tuser))
    else $error("output changed while stalled");

  // every emitted box is ordered on each axis
  a_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_box[0 +: CW])    <= $signed(m_box[3*CW +: CW])) &&
                 ($signed(m_box[CW +: CW])   <= $signed(m_box[4*CW +: CW])) &&
                 ($signed(m_box[2*CW +: CW]) <= $signed(m_box[5*CW +: CW])))
    else $error("box minimum above maximum");

endmodule

bind transform_points_bounding_box fpb_checker #(.COORD_WIDTH(COORD_WIDTH)) u_fpb_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_box    (m_tdata[6*COORD_WIDTH-1:0]),
  .m_tuser  (m_tuser)
);
`default_nettype wire
